@@ rtl/debug_tile_pattern_generator_assert.svh @@
// ----------------------------------------------------------------------------
// Debug tile pattern generator assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DEBUG_TILE_PATTERN_GENERATOR_ASSERT_SVH
`define DEBUG_TILE_PATTERN_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTPG_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTPG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dtpg_pkg.sv @@
// ----------------------------------------------------------------------------
// Debug tile pattern generator package
// Types, constants and small functions shared by the generator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtpg_pkg;

  localparam int PIX_W = 10;
  localparam int CFG_W = 31;
  localparam int ZOOM_W = 5;
  localparam int DIM_REG_W = 11;
  localparam int CH_W = 8;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W = 4 * NUM_DIGITS;
  localparam int CFG_IDX_W = 3;
  localparam int DEF_MAX_TILE_DIM = 1024;
  localparam int RESET_DIM = 256;

  localparam logic [31:0] HASH_ZOOM = 32'd2654435761;
  localparam logic [31:0] HASH_COLUMN = 32'h9e3779b9;
  localparam logic [31:0] HASH_ROW = 32'h517cc1b7;
  localparam logic [31:0] HASH_MIX = 32'h85ebca6b;

  localparam logic [CH_W-1:0] CHAN_LOW = 8'd64;
  localparam logic [CH_W-1:0] CHAN_HIGH = 8'd192;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZOOM   = 3'd0,
    REG_COLUMN = 3'd1,
    REG_ROW    = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_line;
  } pixel_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            outside;
  } pixel_out_t;

  typedef struct packed {
    logic [CH_W-1:0]  base_r;
    logic [CH_W-1:0]  base_g;
    logic [CH_W-1:0]  base_b;
    logic [CH_W-1:0]  dark_r;
    logic [CH_W-1:0]  dark_g;
    logic [CH_W-1:0]  dark_b;
    logic [BCD_W-1:0] bcd_zoom;
    logic [BCD_W-1:0] bcd_col;
    logic [BCD_W-1:0] bcd_row;
    logic [3:0]       n_zoom;
    logic [3:0]       n_col;
    logic [3:0]       n_row;
  } setup_t;

  function automatic logic [CH_W-1:0] clamp_chan(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] r;
    r = c;
    if (c < CHAN_LOW) begin
      r = CHAN_LOW;
    end else if (c > CHAN_HIGH) begin
      r = CHAN_HIGH;
    end
    return r;
  endfunction

  function automatic logic [CH_W-1:0] darken(input logic [CH_W-1:0] c);
    logic [CH_W+10:0] p;
    p = (CH_W+11)'(c) * (CH_W+11)'(615);
    return p[CH_W+10:11];
  endfunction

  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic            bit_in);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  function automatic logic [3:0] digit_count(input logic [BCD_W-1:0] bcd);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 1; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic logic [3:0] bcd_digit(input logic [BCD_W-1:0] bcd,
                                           input logic [3:0]       idx);
    logic [3:0] d;
    d = 4'd0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (idx == 4'(i)) begin
        d = bcd[4*i +: 4];
      end
    end
    return d;
  endfunction

  // Rows of the 3x5 font, top row in the high bits.
  function automatic logic [2:0] font_row(input logic [3:0] d, input logic [2:0] row);
    logic [14:0] g;
    logic [2:0]  r;
    unique case (d)
      4'd0:    g = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      4'd1:    g = {3'd1, 3'd1, 3'd1, 3'd1, 3'd1};
      4'd2:    g = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
      4'd3:    g = {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
      4'd4:    g = {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
      4'd5:    g = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      4'd6:    g = {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
      4'd7:    g = {3'd7, 3'd1, 3'd1, 3'd1, 3'd1};
      4'd8:    g = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
      4'd9:    g = {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
      default: g = 15'd0;
    endcase
    unique case (row)
      3'd0:    r = g[14:12];
      3'd1:    r = g[11:9];
      3'd2:    r = g[8:6];
      3'd3:    r = g[5:3];
      3'd4:    r = g[2:0];
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/debug_tile_pattern_generator.sv @@
// ----------------------------------------------------------------------------
// Debug tile pattern generator
// Produces one test-pattern pixel of a map tile per item.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  pixel_in_t  (pixel_col, pixel_line)
//   out       output     out_valid/out_stall  pixel_out_t (red .. outside)
//   cfg       input      cfg_write            cfg_index, cfg_data
//
// One item is accepted per cycle unless the output stalls, setup runs or
// a register is written. After reset and after every register write the
// setup unit runs its one-bit-per-cycle decimal conversion, and no item
// is accepted meanwhile. A stalled output freezes the whole pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module debug_tile_pattern_generator
  import dtpg_pkg::*;
#(
  parameter int MaxTileDim = DEF_MAX_TILE_DIM
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pixel_in_t            in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pixel_out_t           out_item,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  `include "debug_tile_pattern_generator_assert.svh"

  localparam int DimW = $clog2(MaxTileDim + 1);
  localparam int GeoW = ((DimW > PIX_W) ? DimW : PIX_W) + 3;

  logic [ZOOM_W-1:0]    tile_zoom;
  logic [CFG_W-1:0]     tile_column;
  logic [CFG_W-1:0]     tile_row;
  logic [DIM_REG_W-1:0] tile_width;
  logic [DIM_REG_W-1:0] tile_height;
  logic                 restart;
  logic                 busy;
  logic                 advance;
  logic                 accept;
  setup_t               setup;

  logic signed [GeoW-1:0] wdim;
  logic signed [GeoW-1:0] hdim;
  logic signed [GeoW-1:0] wm1;
  logic signed [GeoW-1:0] hm1;
  logic signed [GeoW-1:0] xhi;
  logic signed [GeoW-1:0] ylo;
  logic signed [GeoW-1:0] yhi;
  logic signed [GeoW-1:0] x0;
  logic signed [GeoW-1:0] y0;

  assign advance = !(out_valid && out_stall);
  assign in_stall = !advance || busy || cfg_write;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_zoom <= '0;
      tile_column <= '0;
      tile_row <= '0;
      tile_width <= DIM_REG_W'(RESET_DIM);
      tile_height <= DIM_REG_W'(RESET_DIM);
      restart <= 1'b1;
    end else begin
      restart <= cfg_write;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ZOOM:   tile_zoom <= cfg_data[ZOOM_W-1:0];
          REG_COLUMN: tile_column <= cfg_data;
          REG_ROW:    tile_row <= cfg_data;
          REG_WIDTH:  tile_width <= cfg_data[DIM_REG_W-1:0];
          REG_HEIGHT: tile_height <= cfg_data[DIM_REG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  dtpg_setup #(
    .MaxTileDim(MaxTileDim),
    .GeoW(GeoW)
  ) u_setup (
    .clk(clk),
    .rst(rst),
    .restart(restart),
    .tile_zoom(tile_zoom),
    .tile_column(tile_column),
    .tile_row(tile_row),
    .tile_width(tile_width),
    .tile_height(tile_height),
    .busy(busy),
    .setup(setup),
    .wdim(wdim),
    .hdim(hdim),
    .wm1(wm1),
    .hm1(hm1),
    .xhi(xhi),
    .ylo(ylo),
    .yhi(yhi),
    .x0(x0),
    .y0(y0)
  );

  dtpg_pipe #(
    .GeoW(GeoW)
  ) u_pipe (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .accept(accept),
    .in_item(in_item),
    .setup(setup),
    .wdim(wdim),
    .hdim(hdim),
    .wm1(wm1),
    .hm1(hm1),
    .xhi(xhi),
    .ylo(ylo),
    .yhi(yhi),
    .x0(x0),
    .y0(y0),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  `DTPG_ASSERT_SAME(a_no_accept_busy, clk, rst, accept, !busy, "item accepted during setup")
  `DTPG_ASSERT_SAME(a_alpha_opaque, clk, rst, out_valid, out_item.alpha == 8'd255, "alpha not opaque")
  `DTPG_ASSERT_SAME(a_outside_black, clk, rst, out_valid && out_item.outside, (out_item.red == 8'd0) && (out_item.green == 8'd0) && (out_item.blue == 8'd0), "outside pixel has color")
  `DTPG_ASSERT_NEXT(a_stall_keeps, clk, rst, out_valid && out_stall, out_valid && $stable(out_item), "stalled result lost")

endmodule

@@ rtl/dtpg_setup.sv @@
// ----------------------------------------------------------------------------
// Debug tile pattern generator setup unit
// Derives the tile colors, the decimal digits and the label geometry from the
// configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtpg_setup
  import dtpg_pkg::*;
#(
  parameter int MaxTileDim = DEF_MAX_TILE_DIM,
  parameter int GeoW = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   restart,
  input  logic [ZOOM_W-1:0]      tile_zoom,
  input  logic [CFG_W-1:0]       tile_column,
  input  logic [CFG_W-1:0]       tile_row,
  input  logic [DIM_REG_W-1:0]   tile_width,
  input  logic [DIM_REG_W-1:0]   tile_height,
  output logic                   busy,
  output setup_t                 setup,
  output logic signed [GeoW-1:0] wdim,
  output logic signed [GeoW-1:0] hdim,
  output logic signed [GeoW-1:0] wm1,
  output logic signed [GeoW-1:0] hm1,
  output logic signed [GeoW-1:0] xhi,
  output logic signed [GeoW-1:0] ylo,
  output logic signed [GeoW-1:0] yhi,
  output logic signed [GeoW-1:0] x0,
  output logic signed [GeoW-1:0] y0
);

  localparam logic signed [GeoW-1:0] MaxDim = GeoW'(MaxTileDim);
  localparam logic signed [GeoW-1:0] C1 = GeoW'(1);
  localparam logic signed [GeoW-1:0] C10 = GeoW'(10);
  localparam logic signed [GeoW-1:0] C16 = GeoW'(16);
  localparam logic signed [GeoW-1:0] C20 = GeoW'(20);
  localparam logic signed [GeoW-1:0] C60 = GeoW'(60);
  localparam logic [5:0] Steps = 6'(CFG_W);

  logic signed [GeoW-1:0] wg;
  logic signed [GeoW-1:0] hg;
  logic signed [GeoW-1:0] half;
  logic signed [GeoW-1:0] wd;

  logic [31:0] pz;
  logic [31:0] pc;
  logic [31:0] pr;
  logic [31:0] mixa;
  logic [31:0] mixa_next;
  logic [31:0] mixm;
  logic [31:0] hs;

  logic [5:0]       cnt;
  logic             running;
  logic [CFG_W-1:0] sz;
  logic [CFG_W-1:0] sc;
  logic [CFG_W-1:0] sr;

  logic [CH_W-1:0]  base_r;
  logic [CH_W-1:0]  base_g;
  logic [CH_W-1:0]  base_b;
  logic [CH_W-1:0]  dark_r;
  logic [CH_W-1:0]  dark_g;
  logic [CH_W-1:0]  dark_b;
  logic [BCD_W-1:0] bcd_zoom;
  logic [BCD_W-1:0] bcd_col;
  logic [BCD_W-1:0] bcd_row;
  logic [3:0]       n_zoom;
  logic [3:0]       n_col;
  logic [3:0]       n_row;

  always_comb begin
    wg = (32'(tile_width) > 32'(MaxTileDim)) ? MaxDim : $signed(GeoW'(tile_width));
    hg = (32'(tile_height) > 32'(MaxTileDim)) ? MaxDim : $signed(GeoW'(tile_height));
    half = hg >>> 1;
    wd = wg - C60;
    mixa_next = pz ^ pc ^ pr;
    hs = mixm ^ (mixm >> 13);
  end

  assign busy = restart | running;
  assign setup = {base_r, base_g, base_b, dark_r, dark_g, dark_b,
                  bcd_zoom, bcd_col, bcd_row, n_zoom, n_col, n_row};

  always_ff @(posedge clk) begin
    wdim <= wg;
    hdim <= hg;
    wm1 <= wg - C1;
    hm1 <= hg - C1;
    xhi <= wg - C20;
    ylo <= half - C16;
    yhi <= half + C16;
    y0 <= half - C10;
    if (wd < 0) begin
      x0 <= -((-wd) >>> 1);
    end else begin
      x0 <= wd >>> 1;
    end

    pz <= 32'(tile_zoom) * HASH_ZOOM;
    pc <= 32'(tile_column) * HASH_COLUMN;
    pr <= 32'(tile_row) * HASH_ROW;
    mixa <= mixa_next ^ (mixa_next >> 16);
    mixm <= mixa * HASH_MIX;
    base_r <= clamp_chan(hs[23:16]);
    base_g <= clamp_chan(hs[15:8]);
    base_b <= clamp_chan(hs[7:0]);
    dark_r <= darken(base_r);
    dark_g <= darken(base_g);
    dark_b <= darken(base_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt <= '0;
    end else if (restart) begin
      running <= 1'b1;
      cnt <= '0;
      sz <= CFG_W'(tile_zoom);
      sc <= tile_column;
      sr <= tile_row;
      bcd_zoom <= '0;
      bcd_col <= '0;
      bcd_row <= '0;
    end else if (running) begin
      if (cnt < Steps) begin
        bcd_zoom <= dabble_step(bcd_zoom, sz[CFG_W-1]);
        bcd_col <= dabble_step(bcd_col, sc[CFG_W-1]);
        bcd_row <= dabble_step(bcd_row, sr[CFG_W-1]);
        sz <= sz << 1;
        sc <= sc << 1;
        sr <= sr << 1;
        cnt <= cnt + 6'd1;
      end else begin
        n_zoom <= digit_count(bcd_zoom);
        n_col <= digit_count(bcd_col);
        n_row <= digit_count(bcd_row);
        running <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/dtpg_pipe.sv @@
// ----------------------------------------------------------------------------
// Debug tile pattern generator pixel pipeline
// Four register stages: geometry tests, glyph cell split, glyph lookup and
// final color selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtpg_pipe
  import dtpg_pkg::*;
#(
  parameter int GeoW = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   accept,
  input  pixel_in_t              in_item,
  input  setup_t                 setup,
  input  logic signed [GeoW-1:0] wdim,
  input  logic signed [GeoW-1:0] hdim,
  input  logic signed [GeoW-1:0] wm1,
  input  logic signed [GeoW-1:0] hm1,
  input  logic signed [GeoW-1:0] xhi,
  input  logic signed [GeoW-1:0] ylo,
  input  logic signed [GeoW-1:0] yhi,
  input  logic signed [GeoW-1:0] x0,
  input  logic signed [GeoW-1:0] y0,
  output logic                   out_valid,
  output pixel_out_t             out_item
);

  localparam int PosW = GeoW - 1;
  localparam int ProdW = PosW + 13;
  localparam logic [12:0] Recip5 = 13'd6554;
  localparam logic signed [GeoW-1:0] C20 = GeoW'(20);
  localparam logic signed [GeoW-1:0] C40 = GeoW'(40);
  localparam logic signed [GeoW-1:0] C4 = GeoW'(4);

  logic signed [GeoW-1:0] xs;
  logic signed [GeoW-1:0] ys;

  logic                   v1;
  logic                   out1;
  logic                   band1;
  logic                   border1;
  logic                   chk1;
  logic signed [GeoW-1:0] dy1;
  logic signed [GeoW-1:0] off1 [3];

  logic [PosW-1:0]  off_u [3];
  logic [ProdW-1:0] prod [3];
  logic [PosW-1:0]  posv [3];
  logic [PosW-1:0]  dxv [3];

  logic            v2;
  logic            out2;
  logic            band2;
  logic            border2;
  logic            chk2;
  logic            dyok2;
  logic [2:0]      dy2;
  logic            ok2 [3];
  logic [PosW-1:0] pos2 [3];
  logic [1:0]      dx2 [3];

  logic [3:0]       ncount [3];
  logic [BCD_W-1:0] digits [3];
  logic [3:0]       idx [3];
  logic [2:0]       frow [3];
  logic             hit_next [3];

  logic v3;
  logic out3;
  logic band3;
  logic border3;
  logic chk3;
  logic hit3 [3];

  always_comb begin
    xs = $signed(GeoW'(in_item.pixel_col));
    ys = $signed(GeoW'(in_item.pixel_line));
    ncount[0] = setup.n_zoom;
    ncount[1] = setup.n_col;
    ncount[2] = setup.n_row;
    digits[0] = setup.bcd_zoom;
    digits[1] = setup.bcd_col;
    digits[2] = setup.bcd_row;
    for (int i = 0; i < 3; i++) begin
      off_u[i] = off1[i][PosW-1:0];
      prod[i] = ProdW'(off_u[i]) * ProdW'(Recip5);
      posv[i] = PosW'(prod[i] >> 15);
      dxv[i] = off_u[i] - PosW'(posv[i] * PosW'(5));
      idx[i] = ncount[i] - 4'd1 - pos2[i][3:0];
      frow[i] = font_row(bcd_digit(digits[i], idx[i]), dy2);
      hit_next[i] = ok2[i] && dyok2 && (pos2[i] < PosW'(ncount[i])) && frow[i][2'd2 - dx2[i]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out1 <= (xs >= wdim) || (ys >= hdim);
      band1 <= (xs > C40) && (xs < xhi) && (ys > ylo) && (ys < yhi);
      border1 <= (xs == 0) || (xs == wm1) || (ys == 0) || (ys == hm1);
      chk1 <= in_item.pixel_col[5] ^ in_item.pixel_line[5];
      dy1 <= ys - y0;
      off1[0] <= xs - x0;
      off1[1] <= xs - x0 - C20;
      off1[2] <= xs - x0 - C40;

      out2 <= out1;
      band2 <= band1;
      border2 <= border1;
      chk2 <= chk1;
      dyok2 <= (dy1 >= 0) && (dy1 <= C4);
      dy2 <= dy1[2:0];
      for (int i = 0; i < 3; i++) begin
        ok2[i] <= !off1[i][GeoW-1] && (dxv[i] <= PosW'(2));
        pos2[i] <= posv[i];
        dx2[i] <= dxv[i][1:0];
      end

      out3 <= out2;
      band3 <= band2;
      border3 <= border2;
      chk3 <= chk2;
      for (int i = 0; i < 3; i++) begin
        hit3[i] <= hit_next[i];
      end

      out_item.alpha <= 8'd255;
      out_item.outside <= out3;
      if (out3) begin
        out_item.red <= 8'd0;
        out_item.green <= 8'd0;
        out_item.blue <= 8'd0;
      end else if (hit3[2]) begin
        out_item.red <= 8'd100;
        out_item.green <= 8'd200;
        out_item.blue <= 8'd255;
      end else if (hit3[1]) begin
        out_item.red <= 8'd255;
        out_item.green <= 8'd180;
        out_item.blue <= 8'd100;
      end else if (hit3[0]) begin
        out_item.red <= 8'd255;
        out_item.green <= 8'd255;
        out_item.blue <= 8'd100;
      end else if (border3) begin
        out_item.red <= 8'd255;
        out_item.green <= 8'd255;
        out_item.blue <= 8'd255;
      end else if (band3) begin
        out_item.red <= 8'd20;
        out_item.green <= 8'd20;
        out_item.blue <= 8'd20;
      end else if (!chk3) begin
        out_item.red <= setup.base_r;
        out_item.green <= setup.base_g;
        out_item.blue <= setup.base_b;
      end else begin
        out_item.red <= setup.dark_r;
        out_item.green <= setup.dark_g;
        out_item.blue <= setup.dark_b;
      end
    end
  end

endmodule
